// ===== hdl/sfc_pkg.sv =====
// shared types, constants and codes for the sphere frustum culling block
package sfc_pkg;

    // plane table geometry
    localparam int PLANES  = 6;
    localparam int PLANE_W = (PLANES > 1) ? $clog2(PLANES) : 1;
    localparam int CNT_W   = $clog2(PLANES + 1);

    // fixed-point formats
    localparam int DATA_W  = 32;
    localparam int Q_FRAC  = 16;
    localparam int PROD_W  = 2 * DATA_W;
    localparam int ACC_W   = DATA_W + 2;
    localparam int DIST_W  = ACC_W + 1;
    localparam int ROOT_W  = PROD_W / 2;
    localparam int RAD_W   = ROOT_W - 1;
    localparam int REM_W   = ROOT_W + 3;
    localparam int SQRT_CNT_W = $clog2(ROOT_W);

    localparam logic signed [DATA_W-1:0] SCALE_ONE = 32'sd65536;
    localparam logic signed [PROD_W-1:0] SAT_HI    = 64'sd2147483647;
    localparam logic signed [PROD_W-1:0] SAT_LO    = -64'sd2147483648;
    localparam logic signed [DATA_W-1:0] Q_MAX     = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] Q_MIN     = 32'sh8000_0000;
    localparam logic signed [ACC_W-1:0]  DIST_MAX  = {1'b0, {(ACC_W-1){1'b1}}};

    // item operation codes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TEST = 1'b1;

    // configuration register byte addresses
    localparam logic [2:0] ADDR_SCALE_X = 3'd0;
    localparam logic [2:0] ADDR_SCALE_Y = 3'd4;

    // multiplier transfer tags
    typedef logic [2:0] tag_t;
    localparam tag_t TAG_NONE = 3'd0;
    localparam tag_t TAG_SX   = 3'd1;
    localparam tag_t TAG_SY   = 3'd2;
    localparam tag_t TAG_SQX  = 3'd3;
    localparam tag_t TAG_SQY  = 3'd4;
    localparam tag_t TAG_PN0  = 3'd5;
    localparam tag_t TAG_PN1  = 3'd6;
    localparam tag_t TAG_PN2  = 3'd7;

    typedef logic signed [DATA_W-1:0] q_t;

    // one frustum plane
    typedef struct packed {
        q_t nx;
        q_t ny;
        q_t nz;
        q_t d;
    } plane_t;

    // multiplier request and response
    typedef struct packed {
        tag_t tag;
        q_t   a;
        q_t   b;
        q_t   d;
    } mul_req_t;

    typedef struct packed {
        tag_t               tag;
        q_t                 q;
        logic [PROD_W-1:0]  raw;
        q_t                 d;
    } mul_rsp_t;

    // square-root unit status
    typedef struct packed {
        logic busy;
        logic done;
    } sqrt_stat_t;

endpackage

// ===== hdl/sfc_plane_mem.sv =====
// six-entry plane table: synchronous memory with per-entry valid bits
module sfc_plane_mem (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        wr_en,
    input  logic [sfc_pkg::PLANE_W-1:0] wr_addr,
    input  sfc_pkg::plane_t             wr_data,
    input  logic [sfc_pkg::PLANE_W-1:0] rd_addr,
    output sfc_pkg::plane_t             rd_data
);

    sfc_pkg::plane_t                plane_mem [sfc_pkg::PLANES];
    sfc_pkg::plane_t                rd_data_reg;
    logic [sfc_pkg::PLANES-1:0]     valid_reg;
    logic                           rd_valid_reg;

    // storage write and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            plane_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= plane_mem[rd_addr];
    end

    // valid bits: an entry never written reads as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

// ===== hdl/sfc_qmul.sv =====
// two-stage q16.16 multiplier with floor, saturation and raw product
module sfc_qmul (
    input  logic              clk,
    input  logic              rst_n,
    input  sfc_pkg::mul_req_t req,
    output sfc_pkg::mul_rsp_t rsp
);

    logic signed [sfc_pkg::PROD_W-1:0] prod;
    logic signed [sfc_pkg::PROD_W-1:0] p1_reg;
    logic signed [sfc_pkg::PROD_W-1:0] shifted;
    sfc_pkg::q_t                       d1_reg;
    sfc_pkg::tag_t                     tag1_reg;
    sfc_pkg::q_t                       sat_q;
    sfc_pkg::q_t                       q2_reg;
    logic [sfc_pkg::PROD_W-1:0]        raw2_reg;
    sfc_pkg::q_t                       d2_reg;
    sfc_pkg::tag_t                     tag2_reg;

    // full signed product
    assign prod = req.a * req.b;

    // floor shift and clamp to 32 bits
    always_comb
    begin
        shifted = p1_reg >>> sfc_pkg::Q_FRAC;
        if (shifted > sfc_pkg::SAT_HI)
        begin
            sat_q = sfc_pkg::Q_MAX;
        end
        else if (shifted < sfc_pkg::SAT_LO)
        begin
            sat_q = sfc_pkg::Q_MIN;
        end
        else
        begin
            sat_q = shifted[sfc_pkg::DATA_W-1:0];
        end
    end

    // data stages
    always_ff @(posedge clk)
    begin
        p1_reg   <= prod;
        d1_reg   <= req.d;
        q2_reg   <= sat_q;
        raw2_reg <= p1_reg;
        d2_reg   <= d1_reg;
    end

    // tags travel alongside the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag1_reg <= sfc_pkg::TAG_NONE;
            tag2_reg <= sfc_pkg::TAG_NONE;
        end
        else
        begin
            tag1_reg <= req.tag;
            tag2_reg <= tag1_reg;
        end
    end

    assign rsp.tag = tag2_reg;
    assign rsp.q   = q2_reg;
    assign rsp.raw = raw2_reg;
    assign rsp.d   = d2_reg;

endmodule

// ===== hdl/sfc_isqrt.sv =====
// iterative integer square root, one result bit per cycle
module sfc_isqrt (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [sfc_pkg::PROD_W-1:0]  radicand,
    output logic [sfc_pkg::ROOT_W-1:0]  root,
    output sfc_pkg::sqrt_stat_t         stat
);

    logic [sfc_pkg::PROD_W-1:0]     rad_reg;
    logic [sfc_pkg::REM_W-1:0]      rem_reg;
    logic [sfc_pkg::ROOT_W-1:0]     root_reg;
    logic [sfc_pkg::REM_W-1:0]      rem_sh;
    logic [sfc_pkg::REM_W-1:0]      trial;
    logic                           take;
    logic [sfc_pkg::SQRT_CNT_W-1:0] cnt_reg;
    logic                           busy_reg;
    logic                           done_reg;

    // one restoring step: bring down two bits, try root*4+1
    always_comb
    begin
        rem_sh = {rem_reg[sfc_pkg::REM_W-3:0], rad_reg[sfc_pkg::PROD_W-1 -: 2]};
        trial  = {1'b0, root_reg, 2'b01};
        take   = (rem_sh >= trial);
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg <= {rad_reg[sfc_pkg::PROD_W-3:0], 2'b00};
            if (take)
            begin
                rem_reg  <= rem_sh - trial;
                root_reg <= {root_reg[sfc_pkg::ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= rem_sh;
                root_reg <= {root_reg[sfc_pkg::ROOT_W-2:0], 1'b0};
            end
        end
    end

    // step counter and status
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg  <= sfc_pkg::SQRT_CNT_W'(sfc_pkg::ROOT_W - 1);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    assign root      = root_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

// ===== hdl/sphere_frustum_cull.sv =====
// top level: bounding-sphere frustum culling sequencer, config port and result register
// a plane load is written into the table as it is transferred; a test item holds item_stall
// until its result is in the output register, and only then is the next item taken
// the 32-step square root sets how long a test runs, the products of the six planes overlap it
// on the shared multiplier; asynchronous active-low reset clears the control state,
// the plane table (through per-entry valid bits) and sets both sprite scales to 1.0
module sphere_frustum_cull (
    input  logic                       clk,
    input  logic                       rst_n,
    // configuration
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [2:0]                 paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    // items
    input  logic                       item_valid,
    output logic                       item_stall,
    input  logic                       op,
    input  logic [2:0]                 plane_index,
    input  logic signed [31:0]         normal_x,
    input  logic signed [31:0]         normal_y,
    input  logic signed [31:0]         normal_z,
    input  logic signed [31:0]         plane_offset,
    input  logic signed [31:0]         pos_x,
    input  logic signed [31:0]         pos_y,
    input  logic signed [31:0]         pos_z,
    input  logic signed [31:0]         obj_scale_x,
    input  logic signed [31:0]         obj_scale_y,
    // results
    output logic                       result_valid,
    input  logic                       result_stall,
    output logic                       visible,
    output logic                       winding_ccw
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_RUN    = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    localparam int         STEP_W      = 4;
    localparam logic [3:0] STEP_SX     = 4'd0;
    localparam logic [3:0] STEP_SY     = 4'd1;
    localparam logic [3:0] STEP_SQX    = 4'd4;
    localparam logic [3:0] STEP_SQY    = 4'd5;
    localparam logic [3:0] STEP_PLANES = 4'd5;
    localparam logic [3:0] STEP_SQRT   = 4'd8;
    localparam logic [3:0] STEP_MAX    = 4'd15;

    localparam logic [1:0] COMP_X = 2'd0;
    localparam logic [1:0] COMP_Y = 2'd1;
    localparam logic [1:0] COMP_Z = 2'd2;

    logic [1:0]                        state_reg, state_next;
    logic [STEP_W-1:0]                 step_reg, step_next;
    logic                              plane_run_reg, plane_run_next;
    logic [sfc_pkg::PLANE_W-1:0]       iss_plane_reg, iss_plane_next;
    logic [1:0]                        iss_comp_reg, iss_comp_next;
    logic [sfc_pkg::CNT_W-1:0]         pdone_cnt_reg;
    logic                              sqrt_done_reg;
    logic                              result_valid_reg, result_valid_next;

    sfc_pkg::q_t                       scale_x_reg, scale_y_reg;
    sfc_pkg::q_t                       pos_x_reg, pos_y_reg, pos_z_reg;
    sfc_pkg::q_t                       obj_sx_reg, obj_sy_reg;
    sfc_pkg::q_t                       sx_reg, sy_reg;
    logic [sfc_pkg::PROD_W-1:0]        sumsq_reg;
    logic signed [sfc_pkg::ACC_W-1:0]  acc_reg, min_reg, plane_dist;
    logic [sfc_pkg::DIST_W-1:0]        dist_fin;
    logic                              visible_reg, winding_reg;

    logic                              accept;
    logic                              test_accept;
    logic                              load_en;
    logic                              out_free;
    logic                              finish_load;
    logic                              sqrt_start;
    logic [sfc_pkg::ROOT_W-1:0]        root;
    logic [sfc_pkg::RAD_W-1:0]         radius;
    sfc_pkg::sqrt_stat_t               sqrt_stat;
    sfc_pkg::plane_t                   wr_plane, rd_plane;
    sfc_pkg::mul_req_t                 mreq;
    sfc_pkg::mul_rsp_t                 mrsp;

    // configuration registers
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_x_reg <= sfc_pkg::SCALE_ONE;
            scale_y_reg <= sfc_pkg::SCALE_ONE;
        end
        else if (psel && penable && pwrite)
        begin
            if (paddr == sfc_pkg::ADDR_SCALE_X)
            begin
                scale_x_reg <= pwdata;
            end
            else if (paddr == sfc_pkg::ADDR_SCALE_Y)
            begin
                scale_y_reg <= pwdata;
            end
        end
    end

    always_comb
    begin
        case (paddr)
            sfc_pkg::ADDR_SCALE_X: prdata = scale_x_reg;
            sfc_pkg::ADDR_SCALE_Y: prdata = scale_y_reg;
            default:               prdata = '0;
        endcase
    end

    // input transfer
    assign item_stall  = (state_reg != ST_IDLE);
    assign accept      = item_valid && !item_stall;
    assign test_accept = accept && (op == sfc_pkg::OP_TEST);
    assign load_en     = accept && (op == sfc_pkg::OP_LOAD) && (plane_index < 3'(sfc_pkg::PLANES));

    assign wr_plane.nx = normal_x;
    assign wr_plane.ny = normal_y;
    assign wr_plane.nz = normal_z;
    assign wr_plane.d  = plane_offset;

    sfc_plane_mem u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (load_en),
        .wr_addr (plane_index[sfc_pkg::PLANE_W-1:0]),
        .wr_data (wr_plane),
        .rd_addr (iss_plane_next),
        .rd_data (rd_plane)
    );

    // result register
    assign out_free    = !result_valid_reg || !result_stall;
    assign finish_load = (state_reg == ST_FINISH) && out_free;

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        case (state_reg)
            ST_IDLE:
            begin
                step_next = '0;
                if (test_accept)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (step_reg != STEP_MAX)
                begin
                    step_next = step_reg + 1'b1;
                end
                if (sqrt_done_reg && (pdone_cnt_reg == sfc_pkg::CNT_W'(sfc_pkg::PLANES)))
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // plane product issue counters
    always_comb
    begin
        plane_run_next = plane_run_reg;
        iss_plane_next = iss_plane_reg;
        iss_comp_next  = iss_comp_reg;
        if (state_reg == ST_IDLE)
        begin
            plane_run_next = 1'b0;
            iss_plane_next = '0;
            iss_comp_next  = COMP_X;
        end
        else if (plane_run_reg)
        begin
            if (iss_comp_reg == COMP_Z)
            begin
                iss_comp_next = COMP_X;
                if (iss_plane_reg == sfc_pkg::PLANE_W'(sfc_pkg::PLANES - 1))
                begin
                    plane_run_next = 1'b0;
                    iss_plane_next = '0;
                end
                else
                begin
                    iss_plane_next = iss_plane_reg + 1'b1;
                end
            end
            else
            begin
                iss_comp_next = iss_comp_reg + 1'b1;
            end
        end
        else if ((state_reg == ST_RUN) && (step_reg == STEP_PLANES))
        begin
            plane_run_next = 1'b1;
        end
    end

    // result valid
    always_comb
    begin
        result_valid_next = result_valid_reg;
        if (finish_load)
        begin
            result_valid_next = 1'b1;
        end
        else if (result_valid_reg && !result_stall)
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            step_reg         <= '0;
            plane_run_reg    <= 1'b0;
            iss_plane_reg    <= '0;
            iss_comp_reg     <= COMP_X;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            step_reg         <= step_next;
            plane_run_reg    <= plane_run_next;
            iss_plane_reg    <= iss_plane_next;
            iss_comp_reg     <= iss_comp_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // multiplier operand selection
    always_comb
    begin
        mreq = '0;
        if (state_reg == ST_RUN)
        begin
            case (step_reg)
                STEP_SX:
                begin
                    mreq.tag = sfc_pkg::TAG_SX;
                    mreq.a   = obj_sx_reg;
                    mreq.b   = scale_x_reg;
                end
                STEP_SY:
                begin
                    mreq.tag = sfc_pkg::TAG_SY;
                    mreq.a   = obj_sy_reg;
                    mreq.b   = scale_y_reg;
                end
                STEP_SQX:
                begin
                    mreq.tag = sfc_pkg::TAG_SQX;
                    mreq.a   = sx_reg;
                    mreq.b   = sx_reg;
                end
                STEP_SQY:
                begin
                    mreq.tag = sfc_pkg::TAG_SQY;
                    mreq.a   = sy_reg;
                    mreq.b   = sy_reg;
                end
                default:
                begin
                    if (plane_run_reg)
                    begin
                        mreq.d = rd_plane.d;
                        case (iss_comp_reg)
                            COMP_X:
                            begin
                                mreq.tag = sfc_pkg::TAG_PN0;
                                mreq.a   = pos_x_reg;
                                mreq.b   = rd_plane.nx;
                            end
                            COMP_Y:
                            begin
                                mreq.tag = sfc_pkg::TAG_PN1;
                                mreq.a   = pos_y_reg;
                                mreq.b   = rd_plane.ny;
                            end
                            COMP_Z:
                            begin
                                mreq.tag = sfc_pkg::TAG_PN2;
                                mreq.a   = pos_z_reg;
                                mreq.b   = rd_plane.nz;
                            end
                            default:
                            begin
                                mreq.tag = sfc_pkg::TAG_NONE;
                            end
                        endcase
                    end
                end
            endcase
        end
    end

    sfc_qmul u_qmul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mreq),
        .rsp   (mrsp)
    );

    // last plane distance, without the radius
    assign plane_dist = acc_reg + sfc_pkg::ACC_W'(mrsp.q);

    // item capture and product collection
    always_ff @(posedge clk)
    begin
        if (test_accept)
        begin
            pos_x_reg  <= pos_x;
            pos_y_reg  <= pos_y;
            pos_z_reg  <= pos_z;
            obj_sx_reg <= obj_scale_x;
            obj_sy_reg <= obj_scale_y;
            min_reg    <= sfc_pkg::DIST_MAX;
        end
        else
        begin
            case (mrsp.tag)
                sfc_pkg::TAG_SX:  sx_reg    <= mrsp.q;
                sfc_pkg::TAG_SY:  sy_reg    <= mrsp.q;
                sfc_pkg::TAG_SQX: sumsq_reg <= mrsp.raw;
                sfc_pkg::TAG_SQY: sumsq_reg <= sumsq_reg + mrsp.raw;
                sfc_pkg::TAG_PN0:
                begin
                    acc_reg <= sfc_pkg::ACC_W'(mrsp.q) + sfc_pkg::ACC_W'(mrsp.d);
                end
                sfc_pkg::TAG_PN1:
                begin
                    acc_reg <= acc_reg + sfc_pkg::ACC_W'(mrsp.q);
                end
                sfc_pkg::TAG_PN2:
                begin
                    if (plane_dist < min_reg)
                    begin
                        min_reg <= plane_dist;
                    end
                end
                default:
                begin
                    acc_reg <= acc_reg;
                end
            endcase
        end
    end

    // plane completion count and square root completion
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pdone_cnt_reg <= '0;
            sqrt_done_reg <= 1'b0;
        end
        else if (test_accept)
        begin
            pdone_cnt_reg <= '0;
            sqrt_done_reg <= 1'b0;
        end
        else
        begin
            if (mrsp.tag == sfc_pkg::TAG_PN2)
            begin
                pdone_cnt_reg <= pdone_cnt_reg + 1'b1;
            end
            if (sqrt_stat.done)
            begin
                sqrt_done_reg <= 1'b1;
            end
        end
    end

    // radius from the sum of squared scales
    assign sqrt_start = (state_reg == ST_RUN) && (step_reg == STEP_SQRT);

    sfc_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (sumsq_reg),
        .root     (root),
        .stat     (sqrt_stat)
    );

    assign radius   = root[sfc_pkg::ROOT_W-1:1];
    assign dist_fin = sfc_pkg::DIST_W'(min_reg) + sfc_pkg::DIST_W'(radius);

    // output payload
    always_ff @(posedge clk)
    begin
        if (finish_load)
        begin
            visible_reg <= !dist_fin[sfc_pkg::DIST_W-1];
            winding_reg <= ((sx_reg > 0) && (sy_reg > 0)) || ((sx_reg < 0) && (sy_reg < 0));
        end
    end

    assign result_valid = result_valid_reg;
    assign visible      = visible_reg;
    assign winding_ccw  = winding_reg;

    // a plane load never starts a test sequence
    a_load_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (op == sfc_pkg::OP_LOAD)) |=> (state_reg == ST_IDLE))
        else $error("plane load left the idle state");

    // a result is only formed after every plane distance has arrived
    a_finish_all_planes: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH) |-> (pdone_cnt_reg == sfc_pkg::CNT_W'(sfc_pkg::PLANES)))
        else $error("finish reached with plane distances outstanding");

    // the square root is started once per test and never while busy
    a_sqrt_start_free: assert property (@(posedge clk) disable iff (!rst_n)
        sqrt_start |-> (!sqrt_stat.busy && !sqrt_done_reg))
        else $error("square root restarted while in use");

    // no multiplier work arrives while idle with nothing in flight
    a_idle_no_products: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_IDLE) && $past(state_reg == ST_IDLE)
            && $past(state_reg == ST_IDLE, 2)) |-> (mrsp.tag == sfc_pkg::TAG_NONE))
        else $error("product delivered with no test running");

endmodule

// ===== dv/sphere_frustum_cull_tb.sv =====
// self-checking testbench for the sphere frustum culling block
module sphere_frustum_cull_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PHASES       = 7;
    localparam int PHASE_ITEMS  = 155;
    localparam int DRAIN_CYCLES = 60;
    localparam int QUIET_PHASE  = 3;

    typedef bit [63:0] u64_t;

    // one input item, every field present whatever the operation
    typedef struct packed {
        logic        op;
        logic [2:0]  idx;
        sfc_pkg::q_t nx;
        sfc_pkg::q_t ny;
        sfc_pkg::q_t nz;
        sfc_pkg::q_t d;
        sfc_pkg::q_t px;
        sfc_pkg::q_t py;
        sfc_pkg::q_t pz;
        sfc_pkg::q_t sx;
        sfc_pkg::q_t sy;
    } cull_item_t;

    typedef struct packed {
        logic vis;
        logic ccw;
    } cull_result_t;

    // plane table, sprite scales and the queue of pending cull verdicts
    class cull_scoreboard;
        sfc_pkg::q_t  scale_x;
        sfc_pkg::q_t  scale_y;
        sfc_pkg::q_t  pl_nx [sfc_pkg::PLANES];
        sfc_pkg::q_t  pl_ny [sfc_pkg::PLANES];
        sfc_pkg::q_t  pl_nz [sfc_pkg::PLANES];
        sfc_pkg::q_t  pl_d  [sfc_pkg::PLANES];
        cull_result_t verdicts [$];
        int           errors;
        int           loads;
        int           dropped_loads;
        int           tests;
        int           culled;
        int           ccw_count;

        function new();
            scale_x = sfc_pkg::SCALE_ONE;
            scale_y = sfc_pkg::SCALE_ONE;
            foreach (pl_nx[i])
            begin
                pl_nx[i] = '0;
                pl_ny[i] = '0;
                pl_nz[i] = '0;
                pl_d[i]  = '0;
            end
            errors        = 0;
            loads         = 0;
            dropped_loads = 0;
            tests         = 0;
            culled        = 0;
            ccw_count     = 0;
        endfunction

        // q16.16 product, floored then saturated
        static function sfc_pkg::q_t fx_mul(sfc_pkg::q_t a, sfc_pkg::q_t b);
            longint prod;
            longint shifted;
            prod    = longint'(a) * longint'(b);
            shifted = prod >>> sfc_pkg::Q_FRAC;
            if (shifted > longint'(sfc_pkg::Q_MAX))
                return sfc_pkg::Q_MAX;
            if (shifted < longint'(sfc_pkg::Q_MIN))
                return sfc_pkg::Q_MIN;
            return sfc_pkg::q_t'(shifted);
        endfunction

        // floor of the integer square root
        static function u64_t root_floor(u64_t v);
            u64_t res;
            u64_t bitv;
            res  = '0;
            bitv = u64_t'(1) << 62;
            while (bitv > v)
                bitv = bitv >> 2;
            while (bitv != 0)
            begin
                if (v >= res + bitv)
                begin
                    v   = v - (res + bitv);
                    res = (res >> 1) + bitv;
                end
                else
                    res = res >> 1;
                bitv = bitv >> 2;
            end
            return res;
        endfunction

        // accepted input transfer: update the table or predict a verdict
        function void note_item(cull_item_t it);
            sfc_pkg::q_t  esx;
            sfc_pkg::q_t  esy;
            longint       sqx;
            longint       sqy;
            u64_t         sq_sum;
            longint       radius;
            longint       plane_dist;
            cull_result_t res;
            if (it.op == sfc_pkg::OP_LOAD)
            begin
                loads++;
                if (it.idx < sfc_pkg::PLANES)
                begin
                    pl_nx[it.idx] = it.nx;
                    pl_ny[it.idx] = it.ny;
                    pl_nz[it.idx] = it.nz;
                    pl_d[it.idx]  = it.d;
                end
                else
                    dropped_loads++;
                return;
            end
            tests++;
            esx    = fx_mul(it.sx, scale_x);
            esy    = fx_mul(it.sy, scale_y);
            sqx    = longint'(esx) * longint'(esx);
            sqy    = longint'(esy) * longint'(esy);
            sq_sum = u64_t'(sqx) + u64_t'(sqy);
            radius = longint'(root_floor(sq_sum) >> 1);
            res.vis = 1'b1;
            for (int i = 0; i < sfc_pkg::PLANES; i++)
            begin
                plane_dist = longint'(fx_mul(it.px, pl_nx[i]))
                           + longint'(fx_mul(it.py, pl_ny[i]))
                           + longint'(fx_mul(it.pz, pl_nz[i])) + longint'(pl_d[i]) + radius;
                if (plane_dist < 0)
                begin
                    res.vis = 1'b0;
                    break;
                end
            end
            res.ccw = (esx > 0 && esy > 0) || (esx < 0 && esy < 0);
            if (!res.vis)
                culled++;
            if (res.ccw)
                ccw_count++;
            verdicts.push_back(res);
        endfunction

        // accepted result transfer against the oldest prediction
        function void check_result(logic vis, logic ccw);
            cull_result_t want;
            if (verdicts.size() == 0)
            begin
                $error("unexpected result: visible=%0b winding_ccw=%0b", vis, ccw);
                errors++;
                return;
            end
            want = verdicts.pop_front();
            if (vis !== want.vis)
            begin
                $error("visible: expected %0b, actual %0b", want.vis, vis);
                errors++;
            end
            if (ccw !== want.ccw)
            begin
                $error("winding_ccw: expected %0b, actual %0b", want.ccw, ccw);
                errors++;
            end
        endfunction
    endclass

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        psel         = 1'b0;
    logic        penable      = 1'b0;
    logic        pwrite       = 1'b0;
    logic [2:0]  paddr        = '0;
    logic [31:0] pwdata       = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        item_valid   = 1'b0;
    logic        item_stall;
    logic        op           = sfc_pkg::OP_LOAD;
    logic [2:0]  plane_index  = '0;
    sfc_pkg::q_t normal_x     = '0;
    sfc_pkg::q_t normal_y     = '0;
    sfc_pkg::q_t normal_z     = '0;
    sfc_pkg::q_t plane_offset = '0;
    sfc_pkg::q_t pos_x        = '0;
    sfc_pkg::q_t pos_y        = '0;
    sfc_pkg::q_t pos_z        = '0;
    sfc_pkg::q_t obj_scale_x  = '0;
    sfc_pkg::q_t obj_scale_y  = '0;
    logic        result_valid;
    logic        result_stall = 1'b0;
    logic        visible;
    logic        winding_ccw;

    bit             gaps_on = 1'b1;
    cull_scoreboard sb;

    sfc_pkg::q_t phase_sx [PHASES] = '{32'sh0001_0000, sfc_pkg::Q_MAX, 32'sh0, 32'sh0,
                                       32'shFFFF_0000, sfc_pkg::Q_MIN, 32'sh0000_0100};
    sfc_pkg::q_t phase_sy [PHASES] = '{32'sh0001_0000, sfc_pkg::Q_MIN, 32'sh0, 32'sh0,
                                       32'sh0001_8000, sfc_pkg::Q_MAX, 32'shFFFF_FF00};

    sphere_frustum_cull dut (.*);

    always #4 clk = ~clk;

    // result side back-pressure
    always @(negedge clk)
        result_stall <= gaps_on && ($urandom_range(0, 99) < 38);

    // result monitor
    always @(posedge clk)
        if (rst_n && result_valid && !result_stall)
            sb.check_result(visible, winding_ccw);

    // run limit
    initial
    begin
        #5_000_000;
        $display("sphere_frustum_cull_tb: errors");
        $finish;
    end

    // mostly moderate values, with full-range words and the extremes mixed in
    function automatic sfc_pkg::q_t rand_q();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 20)
            return sfc_pkg::q_t'($urandom);
        if (pick < 32)
        begin
            case ($urandom_range(0, 6))
                0: return sfc_pkg::Q_MAX;
                1: return sfc_pkg::Q_MIN;
                2: return 32'sh0;
                3: return 32'sh1;
                4: return -32'sh1;
                5: return sfc_pkg::SCALE_ONE;
                default: return -sfc_pkg::SCALE_ONE;
            endcase
        end
        return sfc_pkg::q_t'(int'($urandom_range(0, 2097152)) - 1048576);
    endfunction

    function automatic cull_item_t mk_load(logic [2:0] idx, sfc_pkg::q_t nx, sfc_pkg::q_t ny,
                                           sfc_pkg::q_t nz, sfc_pkg::q_t d);
        cull_item_t it;
        it    = cull_item_t'({$urandom, $urandom, $urandom, $urandom, $urandom,
                              $urandom, $urandom, $urandom, $urandom, $urandom});
        it.op  = sfc_pkg::OP_LOAD;
        it.idx = idx;
        it.nx  = nx;
        it.ny  = ny;
        it.nz  = nz;
        it.d   = d;
        return it;
    endfunction

    function automatic cull_item_t mk_test(sfc_pkg::q_t px, sfc_pkg::q_t py, sfc_pkg::q_t pz,
                                           sfc_pkg::q_t sx, sfc_pkg::q_t sy);
        cull_item_t it;
        it    = cull_item_t'({$urandom, $urandom, $urandom, $urandom, $urandom,
                              $urandom, $urandom, $urandom, $urandom, $urandom});
        it.op = sfc_pkg::OP_TEST;
        it.px = px;
        it.py = py;
        it.pz = pz;
        it.sx = sx;
        it.sy = sy;
        return it;
    endfunction

    // random item: plane offsets lean positive so that a fair share of objects survive
    function automatic cull_item_t rand_item();
        cull_item_t it;
        logic [2:0] idx;
        idx = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(sfc_pkg::PLANES, 7))
                                          : 3'($urandom_range(0, sfc_pkg::PLANES - 1));
        if ($urandom_range(0, 99) < 30)
        begin
            it = mk_load(idx, rand_q(), rand_q(), rand_q(), rand_q());
            if ($urandom_range(0, 1) == 1)
                it.d = sfc_pkg::q_t'($urandom_range(0, 32'h3FFF_FFFF));
            if ($urandom_range(0, 9) == 0)
            begin
                it.nx = '0;
                it.ny = '0;
                it.nz = '0;
            end
        end
        else
        begin
            it     = mk_test(rand_q(), rand_q(), rand_q(), rand_q(), rand_q());
            it.idx = idx;
        end
        return it;
    endfunction

    // one input transfer, with random idle cycles ahead of it
    task automatic send_item(input cull_item_t it);
        while (gaps_on && $urandom_range(0, 99) < 38)
        begin
            @(negedge clk);
            item_valid <= 1'b0;
        end
        @(negedge clk);
        item_valid   <= 1'b1;
        op           <= it.op;
        plane_index  <= it.idx;
        normal_x     <= it.nx;
        normal_y     <= it.ny;
        normal_z     <= it.nz;
        plane_offset <= it.d;
        pos_x        <= it.px;
        pos_y        <= it.py;
        pos_z        <= it.pz;
        obj_scale_x  <= it.sx;
        obj_scale_y  <= it.sy;
        do
            @(posedge clk);
        while (item_stall);
        sb.note_item(it);
    endtask

    // apb write followed by a read-back
    task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata !== data)
        begin
            $error("prdata at %0h: expected %h, actual %h", addr, data, prdata);
            sb.errors++;
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // let the block drain: every verdict in, then room for a trailing load
    task automatic settle();
        @(negedge clk);
        item_valid <= 1'b0;
        while (sb.verdicts.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // main sequence
    initial
    begin
        sb = new();
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: empty table, plane boundaries, ignored slots, saturation, winding
        send_item(mk_test(32'sh0, 32'sh0, 32'sh0, sfc_pkg::SCALE_ONE, sfc_pkg::SCALE_ONE));
        send_item(mk_test(sfc_pkg::Q_MAX, sfc_pkg::Q_MIN, sfc_pkg::Q_MAX, sfc_pkg::Q_MAX,
                          sfc_pkg::Q_MIN));
        send_item(mk_load(3'd0, sfc_pkg::SCALE_ONE, 32'sh0, 32'sh0, 32'sh0));
        send_item(mk_test(-32'sh2_0000, 32'sh0, 32'sh0, sfc_pkg::SCALE_ONE,
                          sfc_pkg::SCALE_ONE));
        send_item(mk_test(-32'sh8000, 32'sh0, 32'sh0, sfc_pkg::SCALE_ONE, sfc_pkg::SCALE_ONE));
        send_item(mk_load(3'd6, sfc_pkg::Q_MIN, sfc_pkg::Q_MIN, sfc_pkg::Q_MIN,
                          sfc_pkg::Q_MIN));
        send_item(mk_load(3'd7, sfc_pkg::Q_MIN, sfc_pkg::Q_MIN, sfc_pkg::Q_MIN,
                          sfc_pkg::Q_MIN));
        send_item(mk_test(32'sh0, 32'sh0, 32'sh0, 32'sh0, 32'sh0));
        send_item(mk_test(-32'sh1, 32'sh0, 32'sh0, 32'sh0, 32'sh0));
        send_item(mk_load(3'd1, 32'sh0, sfc_pkg::Q_MAX, sfc_pkg::Q_MIN, sfc_pkg::Q_MIN));
        send_item(mk_test(32'sh0, sfc_pkg::Q_MAX, 32'sh0, sfc_pkg::SCALE_ONE,
                          sfc_pkg::SCALE_ONE));
        send_item(mk_test(32'sh0, sfc_pkg::Q_MIN, sfc_pkg::Q_MIN, sfc_pkg::SCALE_ONE,
                          sfc_pkg::SCALE_ONE));
        for (int i = 2; i < sfc_pkg::PLANES; i++)
            send_item(mk_load(3'(i), rand_q(), rand_q(), rand_q(), sfc_pkg::Q_MAX));
        send_item(mk_test(32'sh0, 32'sh0, 32'sh0, -32'sh1, 32'sh1));
        send_item(mk_test(32'sh0, 32'sh0, 32'sh0, -32'sh1, -32'sh1));
        send_item(mk_test(sfc_pkg::SCALE_ONE, sfc_pkg::SCALE_ONE, sfc_pkg::SCALE_ONE,
                          -32'sh3_0000, -32'sh2_0000));
        send_item(mk_test(32'sh0, 32'sh0, 32'sh0, sfc_pkg::Q_MIN, sfc_pkg::Q_MIN));
        send_item(mk_load(3'd0, 32'sh0, 32'sh0, 32'sh0, 32'sh0));
        send_item(mk_test(rand_q(), rand_q(), rand_q(), sfc_pkg::Q_MAX, sfc_pkg::Q_MAX));
        send_item(mk_load(3'd1, 32'sh0, 32'sh0, 32'sh0, 32'sh0));

        // random phases, each under its own sprite scales
        for (int phase = 0; phase < PHASES; phase++)
        begin
            if (phase > 0)
            begin
                settle();
                if (phase == QUIET_PHASE)
                begin
                    phase_sx[phase] = sfc_pkg::q_t'($urandom);
                    phase_sy[phase] = sfc_pkg::q_t'($urandom);
                end
                reg_write(sfc_pkg::ADDR_SCALE_X, phase_sx[phase]);
                sb.scale_x = phase_sx[phase];
                reg_write(sfc_pkg::ADDR_SCALE_Y, phase_sy[phase]);
                sb.scale_y = phase_sy[phase];
            end
            gaps_on = (phase != QUIET_PHASE);
            repeat (PHASE_ITEMS) send_item(rand_item());
        end
        gaps_on = 1'b1;
        settle();

        if (sb.verdicts.size() != 0)
        begin
            $error("%0d expected results never arrived", sb.verdicts.size());
            sb.errors++;
        end
        $display("covered %0d plane loads (%0d to unused slots) and %0d object tests",
                 sb.loads, sb.dropped_loads, sb.tests);
        $display("over %0d scale settings: %0d culled, %0d counter-clockwise",
                 PHASES, sb.culled, sb.ccw_count);
        if (sb.errors == 0)
            $display("sphere_frustum_cull_tb: clean");
        else
            $display("sphere_frustum_cull_tb: errors");
        $finish;
    end

endmodule
